// ===== rtl/cfs_pkg.sv =====
package cfs_pkg;

  localparam int unsigned DW = 64;
  localparam int unsigned TW = 6;
  localparam logic [TW-1:0] TRUNC_CAP = 6'd40;
  localparam logic [DW-1:0] POS_ZERO = 64'h0;
  localparam logic [DW-1:0] QNAN = 64'h7FF8_0000_0000_0000;
  // invalid operation result, negative quiet NaN
  localparam logic [DW-1:0] DEF_NAN = 64'hFFF8_0000_0000_0000;

  typedef logic [DW-1:0] f64_t;

  typedef struct packed {
    logic valid;
    logic last;
    f64_t value;
  } req_t;

  // binary64 add, round to nearest even
  function automatic f64_t fadd(input f64_t a, input f64_t b);
    logic        sa, sb, sr, bsign;
    logic [10:0] ea, eb, eg;
    logic [52:0] ma, mb;
    logic [55:0] big, sml, shf;
    logic [56:0] sum;
    logic [11:0] d;
    logic        sticky, lsb, rnd;
    logic [12:0] e;
    logic [5:0]  lz;
    logic [56:0] norm;
    logic [53:0] mr;
    logic        found;
    f64_t        r;
    sa = a[63]; sb = b[63];
    ea = a[62:52]; eb = b[62:52];
    ma = {(ea != 11'd0), a[51:0]};
    mb = {(eb != 11'd0), b[51:0]};
    r = POS_ZERO;
    sticky = 1'b0; lz = '0; found = 1'b0; sum = '0; norm = '0; mr = '0;
    bsign = 1'b0; eg = '0; big = '0; sml = '0; shf = '0; d = '0; e = '0;
    lsb = 1'b0; rnd = 1'b0; sr = 1'b0;
    if ((ea == 11'h7FF && a[51:0] != 0) || (eb == 11'h7FF && b[51:0] != 0)) begin
      r = (ea == 11'h7FF && a[51:0] != 0) ? (a | QNAN) : (b | QNAN);
    end else if (ea == 11'h7FF && eb == 11'h7FF) begin
      r = (sa == sb) ? a : DEF_NAN;
    end else if (ea == 11'h7FF) begin
      r = a;
    end else if (eb == 11'h7FF) begin
      r = b;
    end else begin
      if ({ea, ma} >= {eb, mb}) begin
        bsign = sa; sr = sb; eg = (ea == 0) ? 11'd1 : ea;
        big = {ma, 3'b000}; sml = {mb, 3'b000};
        d = {1'b0, eg} - {1'b0, (eb == 0) ? 11'd1 : eb};
      end else begin
        bsign = sb; sr = sa; eg = (eb == 0) ? 11'd1 : eb;
        big = {mb, 3'b000}; sml = {ma, 3'b000};
        d = {1'b0, eg} - {1'b0, (ea == 0) ? 11'd1 : ea};
      end
      if (d > 12'd56) begin
        shf = '0; sticky = (sml != 0);
      end else begin
        shf = sml >> d[5:0];
        sticky = ((sml & ((56'd1 << d[5:0]) - 56'd1)) != 0);
      end
      shf[0] = shf[0] | sticky;
      if (bsign == sr) sum = {1'b0, big} + {1'b0, shf};
      else sum = {1'b0, big} - {1'b0, shf};
      if (sum == 0) begin
        r = {(sa & sb), 63'd0};
      end else begin
        for (int i = 56; i >= 0; i--) begin
          if (!found && sum[i]) begin
            found = 1'b1; lz = 6'(56 - i);
          end
        end
        // leading one is shifted to bit 56; exponent e refers to that
        e = {2'b0, eg} + 13'd1 - {7'd0, lz};
        if ($signed(e) < 13'sd1) begin
          norm = sum << 6'({7'd0, lz} - (13'd1 - e));
          e = 13'd0;
        end else begin
          norm = sum << lz;
        end
        // norm[56] is leading position, bits 55:4 fraction, 3:0 grs
        lsb = norm[4];
        rnd = norm[3] & ((norm[2:0] != 0) | lsb);
        mr = {1'b0, norm[56:4]} + {53'd0, rnd};
        if (mr[53]) begin
          mr = mr >> 1; e = e + 13'd1;
        end
        if (e == 13'd0 && mr[52]) e = 13'd1;
        if ($signed(e) >= 13'sd2047) r = {bsign, 11'h7FF, 52'd0};
        else r = {bsign, e[10:0], mr[51:0]};
      end
    end
    return r;
  endfunction

  // a - b; a NaN in b passes through with its own sign
  function automatic f64_t fsub(input f64_t a, input f64_t b);
    f64_t r;
    if ((b[62:52] == 11'h7FF && b[51:0] != 0) &&
        !(a[62:52] == 11'h7FF && a[51:0] != 0)) begin
      r = b | QNAN;
    end else begin
      r = fadd(a, {~b[63], b[62:0]});
    end
    return r;
  endfunction

endpackage

// ===== rtl/cfs_datapath.sv =====
module cfs_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  cfs_pkg::req_t  req,
  input  logic [5:0]     trunc,
  output logic           res_valid,
  output cfs_pkg::f64_t  res_value
);
  import cfs_pkg::*;

  f64_t s_r, c_r, s_nxt, c_nxt, y, t, dd, cn, part, tot;
  logic [5:0] k;
  f64_t mask;

  always_comb begin
    y = fadd(req.value, c_r);
    t = fadd(s_r, y);
    dd = fsub(t, s_r);
    cn = fsub(y, dd);
    part = fadd(POS_ZERO, cn);
    tot = fadd(part, t);
    k = (trunc > TRUNC_CAP) ? TRUNC_CAP : trunc;
    mask = (f64_t'(1) << k) - f64_t'(1);
    res_value = tot & ~mask;
    res_valid = req.valid & req.last;
    s_nxt = s_r; c_nxt = c_r;
    if (req.valid) begin
      s_nxt = req.last ? POS_ZERO : t;
      c_nxt = req.last ? POS_ZERO : cn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= POS_ZERO;
      c_r <= POS_ZERO;
    end else begin
      s_r <= s_nxt;
      c_r <= c_nxt;
    end
  end
endmodule

// ===== rtl/compensated_float_sum_core.sv =====
// Path: an accepted request is held in the input reg; its total goes to the result reg or skid slot.
// Throughput: one request per cycle while in_ready is high; the adder chain sits between the regs.
// Output register plus skid slot; in_ready drops only when a new total could overflow both.
// Reset (rst_n low, synchronous): sum and correction +0, truncate_bits 0,
// all pipeline and output slots empty.
module compensated_float_sum_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_total,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_truncate_bits
);
  import cfs_pkg::*;

  req_t req_r, req_nxt;
  logic [5:0] trunc_r;
  logic res_valid;
  f64_t res_value;
  logic ov_r, sv_r;
  f64_t od_r, sd_r;

  cfs_datapath u_dp (
    .clk, .rst_n, .req(req_r), .trunc(trunc_r),
    .res_valid, .res_value
  );

  // at most one output slot may stay occupied after this cycle
  assign in_ready = sv_r ? (out_ready && !res_valid) : (!ov_r || !res_valid || out_ready);
  assign out_valid = ov_r;
  assign out_total = od_r;

  always_comb begin
    req_nxt = '{valid: in_valid & in_ready, last: in_last, value: in_value};
  end

  always_ff @(posedge clk) begin
    req_r.last <= req_nxt.last;
    req_r.value <= req_nxt.value;
    if (!rst_n) begin
      req_r.valid <= 1'b0;
      trunc_r <= '0;
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      req_r.valid <= req_nxt.valid;
      if (cfg_we) trunc_r <= cfg_truncate_bits;
      if (!ov_r || out_ready) begin
        if (sv_r) begin
          ov_r <= 1'b1; od_r <= sd_r; sv_r <= 1'b0;
          if (res_valid) begin
            sv_r <= 1'b1; sd_r <= res_value;
          end
        end else begin
          ov_r <= res_valid; od_r <= res_value;
        end
      end else if (res_valid) begin
        sv_r <= 1'b1; sd_r <= res_value;
      end
    end
  end
endmodule

// ===== rtl/cfs_checker.sv =====
module cfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_total
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total))
    else $error("result dropped under stall");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("unexpected result");
  a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("stalled input with no pending result");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind compensated_float_sum_core cfs_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .in_last,
  .out_valid, .out_ready, .out_total
);

// ===== dv/compensated_float_sum_checker.sv =====
module compensated_float_sum_checker
  import cfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_value,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_total,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_truncate_bits,
  output int          fail_count,
  output int          totals_pending
);

  f64_t       run_sum;
  f64_t       run_corr;
  logic [5:0] trunc_bits;
  f64_t       totals_q[$];

  function automatic logic is_nan(input f64_t a);
    return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input f64_t a);
    return (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
  endfunction

  // binary64 add, round to nearest even; NaN inputs are quieted and inf - inf gives the negative quiet NaN
  function automatic f64_t dbl_add(input f64_t a, input f64_t b);
    real r;
    if (is_nan(a)) return a | QNAN;
    if (is_nan(b)) return b | QNAN;
    if (is_inf(a) && is_inf(b) && (a[63] != b[63])) return 64'hFFF8_0000_0000_0000;
    r = $bitstoreal(a) + $bitstoreal(b);
    return $realtobits(r);
  endfunction

  function automatic f64_t dbl_neg(input f64_t a);
    return {~a[63], a[62:0]};
  endfunction

  // a - b as a + (-b) keeps IEEE semantics except for NaN sign of b
  function automatic f64_t dbl_sub(input f64_t a, input f64_t b);
    if (is_nan(b) && !is_nan(a)) return b | QNAN;
    return dbl_add(a, dbl_neg(b));
  endfunction

  function automatic f64_t truncate_total(input f64_t v, input logic [5:0] n);
    logic [5:0] k;
    f64_t       mask;
    k = (n > TRUNC_CAP) ? TRUNC_CAP : n;
    mask = (64'd1 << k) - 64'd1;
    return v & ~mask;
  endfunction

  task automatic accumulate(input f64_t x, input logic last);
    f64_t y, t, d, tot;
    y = dbl_add(x, run_corr);
    t = dbl_add(run_sum, y);
    d = dbl_sub(t, run_sum);
    run_corr = dbl_sub(y, d);
    run_sum = t;
    if (last) begin
      tot = dbl_add(dbl_add(POS_ZERO, run_corr), run_sum);
      totals_q.push_back(truncate_total(tot, trunc_bits));
      run_sum = POS_ZERO;
      run_corr = POS_ZERO;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      run_sum = POS_ZERO;
      run_corr = POS_ZERO;
      trunc_bits = '0;
      totals_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) trunc_bits = cfg_truncate_bits;
      if (in_valid && in_ready) accumulate(in_value, in_last);
      if (out_valid && out_ready) begin
        if (totals_q.size() == 0) begin
          $display("%0t: unexpected total %h", $time, out_total);
          fail_count++;
        end else begin
          f64_t exp_total;
          exp_total = totals_q.pop_front();
          if (exp_total !== out_total) begin
            $display("%0t: total mismatch expected %h actual %h", $time, exp_total, out_total);
            fail_count++;
          end
        end
      end
    end
    totals_pending = totals_q.size();
  end

endmodule

// ===== dv/tb_compensated_float_sum_core.sv =====
module tb_compensated_float_sum_core;
  import cfs_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_value = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_total;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_truncate_bits = '0;
  int          fail_count;
  int          totals_pending;
  logic        no_idle = 1'b0;
  int          stall_cycles = 0;
  f64_t        prev_term = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  compensated_float_sum_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_total(out_total),
    .cfg_we(cfg_we), .cfg_truncate_bits(cfg_truncate_bits)
  );

  compensated_float_sum_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_total(out_total),
    .cfg_we(cfg_we), .cfg_truncate_bits(cfg_truncate_bits),
    .fail_count(fail_count), .totals_pending(totals_pending)
  );

  always @(posedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("compensated_float_sum_core verification failed");
      $finish;
    end
  end

  task automatic send_request(input f64_t v, input logic last);
    logic rdy;
    if (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    prev_term = v;
  endtask

  task automatic write_trunc(input logic [5:0] n);
    in_valid <= 1'b0;
    @(posedge clk);
    while (totals_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_truncate_bits <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic f64_t random_term();
    int   pick;
    f64_t v;
    pick = $urandom_range(99);
    v = {$urandom, $urandom};
    if (pick < 25) return v;
    if (pick < 35) return {~prev_term[63], prev_term[62:0]};
    if (pick < 40) begin
      case ($urandom_range(5))
        0: return {v[63], 63'd0};
        1: return {v[63], 11'h7FF, 52'd0};
        2: return {v[63], 11'h7FF, v[51:1], 1'b1};
        3: return {v[63], 11'd0, v[51:0]};
        4: return {v[63], 11'h7FE, v[51:0]};
        default: return {v[63], 11'd1, v[51:0]};
      endcase
    end
    return {v[63], 11'(1023 - 40 + $urandom_range(80)), v[51:0]};
  endfunction

  initial begin
    f64_t dir_terms[$];
    int   n, len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-term runs over the extremes, then compensation cases
    dir_terms = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                  64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000};
    foreach (dir_terms[i]) send_request(dir_terms[i], 1'b1);
    send_request(64'h8000_0000_0000_0000, 1'b0);
    send_request(64'h8000_0000_0000_0000, 1'b1);
    send_request(64'h7FF0_0000_0000_0000, 1'b0);
    send_request(64'hFFF0_0000_0000_0000, 1'b1);
    send_request(64'h4340_0000_0000_0000, 1'b0);
    send_request(64'h3FF0_0000_0000_0000, 1'b0);
    send_request(64'h3FF0_0000_0000_0000, 1'b0);
    send_request(64'hC340_0000_0000_0000, 1'b1);
    send_request(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_request(64'h7FEF_FFFF_FFFF_FFFF, 1'b1);

    write_trunc(6'd40);
    send_request(64'h3FF5_5555_5555_5555, 1'b0);
    send_request(64'hBC90_0000_0000_0001, 1'b1);
    write_trunc(6'd63);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(64'h4009_21FB_5444_2D18, 1'b1);
    write_trunc(6'd1);

    n = 0;
    while (n < 850) begin
      no_idle = (n >= 300 && n < 420);
      if (n % 170 == 169) write_trunc(6'($urandom_range(63)));
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
      for (int k = 0; k < len; k++) begin
        send_request(random_term(), k == len - 1);
        n++;
      end
    end
    write_trunc(6'd0);
    send_request(64'h3FF0_0000_0000_0001, 1'b0);
    send_request(64'h3CA0_0000_0000_0000, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (totals_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && totals_pending == 0) begin
      $display("compensated_float_sum_core verification clean");
    end else begin
      $display("compensated_float_sum_core verification failed");
    end
    $finish;
  end

endmodule
